// ===== src/cfr_pkg.sv =====
// Package for the filled circle rasterizer: codes, register map and stage records.
// No dependencies; used by circle_fill_rasterizer.
package cfr_pkg;

	localparam int MAX_DIM = 4096;

	localparam int DIM_W = 13;
	localparam int ADDR_W = 5;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_BRUSH_RED    = 3'd2;
	localparam logic [2:0] REG_BRUSH_GREEN  = 3'd3;
	localparam logic [2:0] REG_BRUSH_BLUE   = 3'd4;

	// What kind of result an item makes
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_IDLE  = 2'd1;
	localparam logic [1:0] KIND_SCAN  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic        done;
		logic        in_box;
		logic [12:0] dx;
		logic [12:0] dy;
		logic [11:0] x;
		logic [11:0] y;
		logic [12:0] w;
		logic [11:0] rad;
	} s1_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        done;
		logic        in_box;
		logic [23:0] dx2;
		logic [23:0] dy2;
		logic [23:0] rr;
		logic [24:0] yw;
		logic [11:0] x;
		logic [11:0] y;
	} s2_t;

endpackage

// ===== src/circle_fill_rasterizer.sv =====
// Filled circle rasterizer: walks the bounding box of a circle, one position per transfer.
// Throughput one item per cycle while the output is not stalled.
// Stage 1 advances the scan state, stage 2 holds the squares and the row product,
// the output register holds the result. Each stage holds while its successor is full.
// Reset clears the scan state and the pipeline at once; the registers return to
// width 256, height 256 and a white brush. Depends on cfr_pkg.
module circle_fill_rasterizer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cfr_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic signed [13:0]           center_x,
	input  logic signed [13:0]           center_y,
	input  logic [11:0]                  radius,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         write_pixel,
	output logic [11:0]                  pixel_x,
	output logic [11:0]                  pixel_y,
	output logic [25:0]                  byte_offset,
	output logic [7:0]                   red_out,
	output logic [7:0]                   green_out,
	output logic [7:0]                   blue_out,
	output logic                         done_res
);

	logic [cfr_pkg::DIM_W-1:0] image_width_q, image_height_q;
	logic [7:0] brush_red_q, brush_green_q, brush_blue_q;

	logic               active_q;
	logic signed [13:0] ctr_x_q, ctr_y_q;
	logic [11:0]        rad_q;
	logic signed [14:0] scan_x_q, scan_y_q;

	logic v_s1, v_s2;
	cfr_pkg::s1_t d_s1, d_s1_n;
	cfr_pkg::s2_t d_s2;

	logic ready_out, ready_s2, ready_s1, accept;
	logic cfg_wr;

	logic [cfr_pkg::DIM_W-1:0] w_eff, h_eff;
	logic signed [14:0] x_hi, y_hi, dx_full, dy_full;
	logic signed [14:0] new_x_lo, new_y_lo, x_lo;
	logic last_x, last_y;

	logic signed [25:0] dx_sq, dy_sq;
	logic [23:0] rr;
	logic [24:0] yw;
	logic [24:0] dist2;
	logic [24:0] pix_idx;
	logic [25:0] off3;
	logic paint;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 13'd256;
			image_height_q <= 13'd256;
			brush_red_q    <= 8'd255;
			brush_green_q  <= 8'd255;
			brush_blue_q   <= 8'd255;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				cfr_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[12:0];
				cfr_pkg::REG_IMAGE_HEIGHT: image_height_q <= pwdata[12:0];
				cfr_pkg::REG_BRUSH_RED:    brush_red_q    <= pwdata[7:0];
				cfr_pkg::REG_BRUSH_GREEN:  brush_green_q  <= pwdata[7:0];
				cfr_pkg::REG_BRUSH_BLUE:   brush_blue_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			cfr_pkg::REG_IMAGE_WIDTH:  prdata = {19'd0, image_width_q};
			cfr_pkg::REG_IMAGE_HEIGHT: prdata = {19'd0, image_height_q};
			cfr_pkg::REG_BRUSH_RED:    prdata = {24'd0, brush_red_q};
			cfr_pkg::REG_BRUSH_GREEN:  prdata = {24'd0, brush_green_q};
			cfr_pkg::REG_BRUSH_BLUE:   prdata = {24'd0, brush_blue_q};
			default:                   prdata = 32'd0;
		endcase
	end

	// handshake: each stage loads when empty or when its successor takes
	assign ready_out = !out_valid || !out_stall;
	assign ready_s2  = !v_s2 || ready_out;
	assign ready_s1  = !v_s1 || ready_s2;
	assign in_stall  = !ready_s1;
	assign accept    = in_valid && ready_s1;

	// clamp dimensions to the largest supported image
	assign w_eff = (image_width_q < cfr_pkg::DIM_W'(cfr_pkg::MAX_DIM)) ?
		image_width_q : cfr_pkg::DIM_W'(cfr_pkg::MAX_DIM);
	assign h_eff = (image_height_q < cfr_pkg::DIM_W'(cfr_pkg::MAX_DIM)) ?
		image_height_q : cfr_pkg::DIM_W'(cfr_pkg::MAX_DIM);

	// box corners of the current circle
	assign x_hi = $signed({ctr_x_q[13], ctr_x_q}) + $signed({3'b000, rad_q});
	assign y_hi = $signed({ctr_y_q[13], ctr_y_q}) + $signed({3'b000, rad_q});
	assign x_lo = $signed({ctr_x_q[13], ctr_x_q}) - $signed({3'b000, rad_q});
	assign new_x_lo = $signed({center_x[13], center_x}) - $signed({3'b000, radius});
	assign new_y_lo = $signed({center_y[13], center_y}) - $signed({3'b000, radius});
	assign last_x = scan_x_q >= x_hi;
	assign last_y = scan_y_q >= y_hi;
	assign dx_full = scan_x_q - $signed({ctr_x_q[13], ctr_x_q});
	assign dy_full = scan_y_q - $signed({ctr_y_q[13], ctr_y_q});

	always_comb begin
		d_s1_n = '0;
		d_s1_n.dx  = dx_full[12:0];
		d_s1_n.dy  = dy_full[12:0];
		d_s1_n.x   = scan_x_q[11:0];
		d_s1_n.y   = scan_y_q[11:0];
		d_s1_n.w   = w_eff;
		d_s1_n.rad = rad_q;
		d_s1_n.in_box = !scan_x_q[14] && (scan_x_q[13:0] < {1'b0, w_eff}) &&
			!scan_y_q[14] && (scan_y_q[13:0] < {1'b0, h_eff});
		if (op == cfr_pkg::OP_START) begin
			d_s1_n.kind = cfr_pkg::KIND_START;
			d_s1_n.done = 1'b0;
		end else if (!active_q) begin
			d_s1_n.kind = cfr_pkg::KIND_IDLE;
			d_s1_n.done = 1'b1;
		end else begin
			d_s1_n.kind = cfr_pkg::KIND_SCAN;
			d_s1_n.done = last_x && last_y;
		end
	end

	// scan state loads on a start transfer and advances at each step transfer while active
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ctr_x_q  <= '0;
			ctr_y_q  <= '0;
			rad_q    <= '0;
			scan_x_q <= '0;
			scan_y_q <= '0;
		end else if (accept) begin
			if (op == cfr_pkg::OP_START) begin
				active_q <= 1'b1;
				ctr_x_q  <= center_x;
				ctr_y_q  <= center_y;
				rad_q    <= radius;
				scan_x_q <= new_x_lo;
				scan_y_q <= new_y_lo;
			end else if (active_q) begin
				if (last_x) begin
					scan_x_q <= x_lo;
					if (last_y) begin
						active_q <= 1'b0;
					end else begin
						scan_y_q <= scan_y_q + 15'sd1;
					end
				end else begin
					scan_x_q <= scan_x_q + 15'sd1;
				end
			end
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_s1 <= d_s1_n;
		end
	end

	// stage 2: squares and row product
	assign dx_sq = $signed({{13{d_s1.dx[12]}}, d_s1.dx}) * $signed({{13{d_s1.dx[12]}}, d_s1.dx});
	assign dy_sq = $signed({{13{d_s1.dy[12]}}, d_s1.dy}) * $signed({{13{d_s1.dy[12]}}, d_s1.dy});
	assign rr    = {12'd0, d_s1.rad} * {12'd0, d_s1.rad};
	assign yw    = {13'd0, d_s1.y} * {12'd0, d_s1.w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			d_s2.kind   <= d_s1.kind;
			d_s2.done   <= d_s1.done;
			d_s2.in_box <= d_s1.in_box;
			d_s2.dx2    <= dx_sq[23:0];
			d_s2.dy2    <= dy_sq[23:0];
			d_s2.rr     <= rr;
			d_s2.yw     <= yw;
			d_s2.x      <= d_s1.x;
			d_s2.y      <= d_s1.y;
		end
	end

	// result stage: distance test and byte offset
	assign dist2   = {1'b0, d_s2.dx2} + {1'b0, d_s2.dy2};
	assign paint   = (d_s2.kind == cfr_pkg::KIND_SCAN) && d_s2.in_box &&
		(dist2 < {1'b0, d_s2.rr});
	assign pix_idx = d_s2.yw + {13'd0, d_s2.x};
	assign off3    = {pix_idx, 1'b0} + {1'b0, pix_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_out) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && v_s2) begin
			write_pixel <= paint;
			pixel_x     <= paint ? d_s2.x : 12'd0;
			pixel_y     <= paint ? d_s2.y : 12'd0;
			byte_offset <= paint ? off3 : 26'd0;
			red_out     <= paint ? brush_red_q : 8'd0;
			green_out   <= paint ? brush_green_q : 8'd0;
			blue_out    <= paint ? brush_blue_q : 8'd0;
			done_res    <= d_s2.done;
		end
	end

	// a stall at the input always means stage 1 is holding an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("input stalled with stage 1 empty");

	// the scan ends only on a step that leaves a done mark in stage 1
	a_done_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(active_q) |-> (v_s1 && d_s1.done && d_s1.kind == cfr_pkg::KIND_SCAN))
		else $error("scan ended without a done mark");

	// painted pixels lie inside the image
	a_paint_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_pixel) |->
			({1'b0, pixel_x} < w_eff) && ({1'b0, pixel_y} < h_eff))
		else $error("painted pixel outside the image");

	// a result without a write carries no coordinates or colour
	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_pixel) |->
			(pixel_x == 12'd0 && pixel_y == 12'd0 && byte_offset == 26'd0 &&
			red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0))
		else $error("non-writing result carries data");

endmodule

// ===== bench/tb_circle_fill_rasterizer.sv =====
// Self-checking bench for circle_fill_rasterizer: directed table, then random circle scans
// under several register settings, each result checked against its typed table entry or an in-bench scan predictor.
// Depends on cfr_pkg and circle_fill_rasterizer.
module tb_circle_fill_rasterizer;

	localparam int PIPE_DEPTH  = 3;
	localparam int TOTAL_ITEMS = 1550;
	localparam int N_PHASES    = 8;
	localparam int CALM_PHASE  = 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam logic TYPED     = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef struct packed {
		logic        op;
		logic [13:0] cx;
		logic [13:0] cy;
		logic [11:0] rad;
	} item_t;

	typedef struct packed {
		logic        wr;
		logic [11:0] x;
		logic [11:0] y;
		logic [25:0] off;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        done;
	} pix_t;

	typedef struct packed {
		item_t it;
		logic  typed;
		pix_t  res;
	} dir_row_t;

	typedef struct packed {
		logic [12:0] w;
		logic [12:0] h;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} cfg_t;

	localparam pix_t PIX_NONE = '0;
	localparam pix_t PIX_DONE = '{done: 1'b1, default: '0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [cfr_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = cfr_pkg::OP_STEP;
	logic signed [13:0] center_x = '0;
	logic signed [13:0] center_y = '0;
	logic [11:0] radius = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic write_pixel;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [25:0] byte_offset;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic done_res;

	circle_fill_rasterizer i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .center_x(center_x), .center_y(center_y), .radius(radius),
		.out_valid(out_valid), .out_stall(out_stall),
		.write_pixel(write_pixel), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.byte_offset(byte_offset), .red_out(red_out), .green_out(green_out),
		.blue_out(blue_out), .done_res(done_res)
	);

	always #2 clk = ~clk;

	// Scan predictor state and its copy of the registers
	logic        scan_on;
	int          c_x, c_y, rad, sx, sy;
	logic [12:0] img_w, img_h;
	logic [7:0]  brush_r, brush_g, brush_b;

	pix_t expected_pixels[$];
	int   idle_pct = 38;
	int   mismatches = 0;
	int   items_sent = 0;
	int   results_seen = 0;
	int   pixels_painted = 0;
	int   scans_finished = 0;
	int   cycle_count = 0;

	dir_row_t directed_rows [23] = '{
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, TYPED, PIX_DONE},  // nothing active
		'{'{cfr_pkg::OP_START, 14'h0000, 14'h0000, 12'd0}, TYPED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, TYPED, PIX_DONE},  // zero radius
		'{'{cfr_pkg::OP_START, 14'h0001, 14'h0001, 12'd1}, TYPED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		// most negative / most positive centres with the largest radius
		'{'{cfr_pkg::OP_START, 14'h2000, 14'h1FFF, 12'hFFF}, TYPED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h3FFF, 14'h3FFF, 12'hFFF}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_START, 14'h1FFF, 14'h2000, 12'hFFF}, TYPED, PIX_NONE},  // abandon
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		// last pixel of a 256 x 256 image must still be painted
		'{'{cfr_pkg::OP_START, 14'd255, 14'd255, 12'd1}, TYPED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE},
		'{'{cfr_pkg::OP_STEP,  14'h0000, 14'h0000, 12'd0}, PREDICTED, PIX_NONE}
	};

	cfg_t phase_cfgs [N_PHASES] = '{
		'{13'd16,   13'd12,   8'h12, 8'h34, 8'h56},
		'{13'd1,    13'd1,    8'h00, 8'h00, 8'h00},
		'{13'd4096, 13'd4096, 8'hFF, 8'hFF, 8'hFF},
		'{13'd0,    13'd37,   8'hA5, 8'h5A, 8'hC3},
		'{13'd8191, 13'd8191, 8'h01, 8'h80, 8'hFE},
		'{13'd100,  13'd0,    8'h7F, 8'h3C, 8'h81},
		'{13'd5000, 13'd3,    8'h0F, 8'hF0, 8'h99},
		'{13'd23,   13'd4095, 8'h66, 8'hB2, 8'h2D}
	};

	function automatic pix_t rasterise_step(input item_t it);
		pix_t   res;
		longint w, h, dx, dy;
		res = '0;
		if (it.op == cfr_pkg::OP_START) begin
			c_x = int'($signed(it.cx));
			c_y = int'($signed(it.cy));
			rad = int'(it.rad);
			sx = c_x - rad;
			sy = c_y - rad;
			scan_on = 1'b1;
			return res;
		end
		if (!scan_on) begin
			res.done = 1'b1;
			return res;
		end
		w = (img_w < cfr_pkg::MAX_DIM) ? longint'(img_w) : longint'(cfr_pkg::MAX_DIM);
		h = (img_h < cfr_pkg::MAX_DIM) ? longint'(img_h) : longint'(cfr_pkg::MAX_DIM);
		dx = sx - c_x;
		dy = sy - c_y;
		if (sx >= 0 && sx < w && sy >= 0 && sy < h && dx * dx + dy * dy < longint'(rad) * rad) begin
			res.wr = 1'b1;
			res.x = sx[11:0];
			res.y = sy[11:0];
			res.off = 26'(3 * (sy * w + sx));
			res.red = brush_r;
			res.green = brush_g;
			res.blue = brush_b;
		end
		// advance along the row, wrap to the next row, finish after the last corner
		if (sx >= c_x + rad) begin
			sx = c_x - rad;
			if (sy >= c_y + rad) begin
				scan_on = 1'b0;
				res.done = 1'b1;
			end else begin
				sy++;
			end
		end else begin
			sx++;
		end
		return res;
	endfunction

	task automatic flag_failure(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("  mismatch at cycle %0d: %s", cycle_count, msg);
		end
	endtask

	// Present one item; predict its result once the transfer is certain
	task automatic send_item(input item_t it, input logic typed, input pix_t typed_res);
		pix_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		center_x <= it.cx;
		center_y <= it.cy;
		radius <= it.rad;
		do @(negedge clk); while (in_stall);
		predicted = rasterise_step(it);
		expected_pixels.push_back(typed ? typed_res : predicted);
		items_sent++;
		@(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			cfr_pkg::REG_IMAGE_WIDTH:  img_w = val[12:0];
			cfr_pkg::REG_IMAGE_HEIGHT: img_h = val[12:0];
			cfr_pkg::REG_BRUSH_RED:    brush_r = val[7:0];
			cfr_pkg::REG_BRUSH_GREEN:  brush_g = val[7:0];
			cfr_pkg::REG_BRUSH_BLUE:   brush_b = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Hold the sender until every result is back and the pipeline has emptied
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// Centre near the low edge, near the high edge, inside the image, or anywhere
	function automatic logic [13:0] pick_coord(input int span, input int r);
		int v;
		case ($urandom_range(3))
			0: v = int'($urandom_range(2 * r + 2)) - r - 1;
			1: v = span - 1 + int'($urandom_range(2 * r + 2)) - r - 1;
			2: v = int'($urandom_range(span - 1));
			default: v = int'($signed(14'($urandom)));
		endcase
		if (v > 8191) v = 8191;
		if (v < -8192) v = -8192;
		return 14'(v);
	endfunction

	task automatic run_circles(input int quota);
		int    sent, r, box, steps, w_span, h_span, pick;
		item_t it;
		sent = 0;
		w_span = (img_w == 0) ? 1 :
			((img_w < cfr_pkg::MAX_DIM) ? int'(img_w) : cfr_pkg::MAX_DIM);
		h_span = (img_h == 0) ? 1 :
			((img_h < cfr_pkg::MAX_DIM) ? int'(img_h) : cfr_pkg::MAX_DIM);
		while (sent < quota) begin
			if ($urandom_range(99) < 6) begin
				// stray item with every field random
				it.op = 1'($urandom_range(1));
				it.cx = 14'($urandom);
				it.cy = 14'($urandom);
				it.rad = 12'($urandom);
				send_item(it, PREDICTED, PIX_NONE);
				sent++;
			end else begin
				pick = $urandom_range(99);
				if (pick < 50) r = $urandom_range(3);
				else if (pick < 90) r = $urandom_range(8, 4);
				else r = $urandom_range(4095);
				box = (2 * r + 1) * (2 * r + 1);
				if (r > 8 || $urandom_range(99) < 15) begin
					steps = $urandom_range((box < 40) ? box : 40, 1);
				end else begin
					steps = box + (($urandom_range(99) < 10) ? $urandom_range(3, 1) : 0);
				end
				// keep the phase at its quota
				if (steps > quota - sent - 1) steps = quota - sent - 1;
				it.op = cfr_pkg::OP_START;
				it.cx = pick_coord(w_span, r);
				it.cy = pick_coord(h_span, r);
				it.rad = 12'(r);
				send_item(it, PREDICTED, PIX_NONE);
				it.op = cfr_pkg::OP_STEP;
				for (int s = 0; s < steps; s++) begin
					it.cx = 14'($urandom);
					it.cy = 14'($urandom);
					it.rad = 12'($urandom);
					send_item(it, PREDICTED, PIX_NONE);
				end
				sent += 1 + steps;
			end
		end
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	always @(negedge clk) begin : check_result
		pix_t  got, want;
		string bad;
		if (arst_n && out_valid && !out_stall) begin
			got = {write_pixel, pixel_x, pixel_y, byte_offset, red_out, green_out, blue_out,
				done_res};
			results_seen++;
			if (got.wr === 1'b1) pixels_painted++;
			if (got.done === 1'b1) scans_finished++;
			if (expected_pixels.size() == 0) begin
				flag_failure($sformatf("result %0d arrived with nothing pending", results_seen));
			end else begin
				want = expected_pixels.pop_front();
				bad = "";
				if (got.wr !== want.wr)
					bad = {bad, $sformatf(" write_pixel exp %0d got %0d", want.wr, got.wr)};
				if (got.x !== want.x)
					bad = {bad, $sformatf(" pixel_x exp %0d got %0d", want.x, got.x)};
				if (got.y !== want.y)
					bad = {bad, $sformatf(" pixel_y exp %0d got %0d", want.y, got.y)};
				if (got.off !== want.off)
					bad = {bad, $sformatf(" byte_offset exp %0d got %0d", want.off, got.off)};
				if (got.red !== want.red)
					bad = {bad, $sformatf(" red_out exp %0d got %0d", want.red, got.red)};
				if (got.green !== want.green)
					bad = {bad, $sformatf(" green_out exp %0d got %0d", want.green, got.green)};
				if (got.blue !== want.blue)
					bad = {bad, $sformatf(" blue_out exp %0d got %0d", want.blue, got.blue)};
				if (got.done !== want.done)
					bad = {bad, $sformatf(" done_res exp %0d got %0d", want.done, got.done)};
				if (bad != "") flag_failure($sformatf("result %0d:%s", results_seen, bad));
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** circle_fill_rasterizer: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int quota;
		scan_on = 1'b0;
		c_x = 0;
		c_y = 0;
		rad = 0;
		sx = 0;
		sy = 0;
		img_w = 13'd256;
		img_h = 13'd256;
		brush_r = 8'hFF;
		brush_g = 8'hFF;
		brush_b = 8'hFF;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
		end
		wait_for_idle();

		quota = (TOTAL_ITEMS - $size(directed_rows)) / N_PHASES;
		for (int p = 0; p < N_PHASES; p++) begin
			apb_write(cfr_pkg::REG_IMAGE_WIDTH, 32'(phase_cfgs[p].w));
			apb_write(cfr_pkg::REG_IMAGE_HEIGHT, 32'(phase_cfgs[p].h));
			apb_write(cfr_pkg::REG_BRUSH_RED, 32'(phase_cfgs[p].red));
			apb_write(cfr_pkg::REG_BRUSH_GREEN, 32'(phase_cfgs[p].green));
			apb_write(cfr_pkg::REG_BRUSH_BLUE, 32'(phase_cfgs[p].blue));
			// one phase runs flat out on both sides
			idle_pct = (p == CALM_PHASE) ? 0 : 38;
			run_circles(quota);
			wait_for_idle();
		end

		if (expected_pixels.size() != 0) begin
			flag_failure($sformatf("%0d results never arrived", expected_pixels.size()));
		end
		$display("Sent %0d items over %0d register settings plus reset values.",
			items_sent, N_PHASES);
		$display("Checked %0d results: %0d pixels painted, %0d done marks, %0d mismatches.",
			results_seen, pixels_painted, scans_finished, mismatches);
		if (mismatches == 0) begin
			$display("** circle_fill_rasterizer: PASSED **");
		end else begin
			$display("** circle_fill_rasterizer: FAILED **");
		end
		$finish;
	end

endmodule
